// ===== src/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg: shared definitions for the chirp message sequencer
// Message length, pause length, tick length, register indexes and the
// constants of the divide-by-1000 used when scaling the chirp slope.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int unsigned SYMBOLS_PER_MESSAGE = 4;
  localparam int unsigned PAUSE_TICKS         = 2;
  localparam int unsigned TICK_MS             = 50;

  // Pause counter runs up to PAUSE_TICKS + 1.
  localparam int unsigned PcW = $clog2(PAUSE_TICKS + 2);

  // floor(x / 1000) = floor((x >> 3) * DivRecip >> DivShift) for x < 2^31.
  localparam int unsigned DivPreShift = 3;
  localparam int unsigned DivShift    = 35;
  localparam int unsigned DivRecipW   = 29;
  localparam logic [DivRecipW-1:0] DivRecip = 29'd274877907;
  localparam int unsigned QuoW        = 22;

  // Cycles that the scaling pipeline needs before the input may be taken.
  localparam int unsigned SettleCycles = 2;
  localparam int unsigned SettleW      = 2;

  typedef enum logic [1:0] {
    CfgChirpLen = 2'd0,
    CfgCenter   = 2'd1,
    CfgSlope    = 2'd2,
    CfgMessage  = 2'd3
  } cfg_idx_e;

  // Sweep band and step derived from the configuration.
  typedef struct packed {
    logic [15:0] bottom;
    logic [15:0] top;
    logic [15:0] step;
  } cms_band_t;

endpackage

// ===== src/cms_scale.sv =====
// ----------------------------------------------------------------------------
// cms_scale: chirp band and step computation
// Scales the chirp slope by the chirp length and by the tick length, divides
// by 1000 with truncation toward zero and forms the band around the centre.
// Three register stages: product, reciprocal product, band.
// ----------------------------------------------------------------------------
module cms_scale import cms_pkg::*; (
  input  logic        clk_i,
  input  logic [15:0] chirp_len_i,
  input  logic [15:0] center_i,
  input  logic [15:0] slope_i,
  output cms_band_t   band_o
);

  localparam logic [10:0] TickMs = 11'(TICK_MS);

  logic signed [32:0] len_prod;
  logic signed [32:0] tick_prod;
  logic [31:0]        len_prod_q, tick_prod_q;

  logic [QuoW-1:0]    len_quo_d, tick_quo_d;
  logic [QuoW-1:0]    len_quo_q, tick_quo_q;
  logic               len_neg_q, tick_neg_q;

  logic [15:0]        total, step, total_adj, half;
  cms_band_t          band_d, band_q;

  // Magnitude of a signed product divided by 1000, rounded down.
  function automatic logic [QuoW-1:0] div1000(input logic [31:0] p);
    logic [31:0]                  mag;
    logic [30-DivPreShift:0]      y;
    logic [30-DivPreShift+DivRecipW:0] pr;
    mag = p[31] ? (~p + 32'd1) : p;
    y   = mag[30:DivPreShift];
    pr  = y * DivRecip;
    return pr[DivShift+QuoW-1:DivShift];
  endfunction

  assign len_prod  = $signed(slope_i) * $signed({1'b0, chirp_len_i});
  assign tick_prod = $signed(slope_i) * $signed({1'b0, 5'd0, TickMs});

  always_ff @(posedge clk_i) begin
    len_prod_q  <= len_prod[31:0];
    tick_prod_q <= tick_prod[31:0];
  end

  assign len_quo_d  = div1000(len_prod_q);
  assign tick_quo_d = div1000(tick_prod_q);

  always_ff @(posedge clk_i) begin
    len_quo_q  <= len_quo_d;
    tick_quo_q <= tick_quo_d;
    len_neg_q  <= len_prod_q[31];
    tick_neg_q <= tick_prod_q[31];
  end

  always_comb begin
    total = len_neg_q  ? (~len_quo_q[15:0] + 16'd1)  : len_quo_q[15:0];
    step  = tick_neg_q ? (~tick_quo_q[15:0] + 16'd1) : tick_quo_q[15:0];
    // Halving rounds toward zero: add one to negative values before the shift.
    total_adj     = total + {15'd0, total[15]};
    half          = {total_adj[15], total_adj[15:1]};
    band_d.bottom = center_i - half;
    band_d.top    = center_i + half;
    band_d.step   = step;
  end

  always_ff @(posedge clk_i) begin
    band_q <= band_d;
  end

  assign band_o = band_q;

endmodule

// ===== src/chirp_message_sequencer.sv =====
// ----------------------------------------------------------------------------
// chirp_message_sequencer: chirped tone message sender
// One input item per tick; each tick returns whether the motor frequency is
// written, the value written and whether a message is still in progress.
// ----------------------------------------------------------------------------
// The block takes one tick item per clock cycle unless the output stalls or
// the scaling settles, and returns one result item per tick via an input
// register, then the result register feeding the output stream; the tick
// update is a single pass of compare and add logic. After reset and every
// configuration write, s_axis_tready stays low while the three-stage slope
// scaling pipeline (multiply, reciprocal divide by 1000, band add) settles.
module chirp_message_sequencer import cms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_request, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] freq_write, [16:1] freq_value,
                                      // [17] busy_res, [23:18] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef struct packed {
    logic [15:0] cur;
    logic [15:0] endf;
    logic [15:0] step;
    logic [3:0]  idx;
  } sym_t;

  // Configuration registers.
  logic [15:0] chirp_len_q, center_q, slope_q;
  logic [7:0]  message_q;
  logic [SettleW-1:0] settle_q;

  cms_band_t band;

  // Handshake.
  logic in_vld_q, start_q, out_vld_q, advance, s_accept;
  logic out_write_q, out_busy_q;
  logic [15:0] out_value_q;

  // Sequencer state.
  logic           pend_q, send_q, pause_q;
  logic [PcW-1:0] pc_q;
  logic [3:0]     idx_q;
  logic [15:0]    cur_q, last_q, endf_q, stepsg_q, bot_q, top_q, stepsz_q;
  logic [7:0]     msg_q;

  logic           pend_d, send_d, pause_d;
  logic [PcW-1:0] pc_d;
  logic [3:0]     idx_d;
  logic [15:0]    cur_d, last_d, endf_d, stepsg_d, bot_d, top_d, stepsz_d;
  logic [7:0]     msg_d;
  logic           wrote;
  logic [15:0]    written;

  function automatic sym_t begin_sym(input logic [7:0] msg, input logic [3:0] idx,
                                     input logic [15:0] bot, input logic [15:0] top,
                                     input logic [15:0] stp);
    sym_t s;
    if (msg[idx[2:0]]) begin
      s.cur  = bot;
      s.endf = top;
      s.step = stp;
    end else begin
      s.cur  = top;
      s.endf = bot;
      s.step = ~stp + 16'd1;
    end
    s.idx = idx + 4'd1;
    return s;
  endfunction

  cms_scale u_scale (
    .clk_i      (clk_i),
    .chirp_len_i(chirp_len_q),
    .center_i   (center_q),
    .slope_i    (slope_q),
    .band_o     (band)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chirp_len_q <= 16'd500;
      center_q    <= 16'd16000;
      slope_q     <= 16'd2000;
      message_q   <= 8'hAA;
      settle_q    <= SettleW'(SettleCycles);
    end else if (cfg_we_i) begin
      settle_q <= SettleW'(SettleCycles);
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgChirpLen: chirp_len_q <= cfg_data_i;
        CfgCenter:   center_q    <= cfg_data_i;
        CfgSlope:    slope_q     <= cfg_data_i;
        CfgMessage:  message_q   <= cfg_data_i[7:0];
        default:     ;
      endcase
    end else if (settle_q != '0) begin
      settle_q <= settle_q - SettleW'(1);
    end
  end

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (settle_q == '0) && (!in_vld_q || advance);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // One tick of the sequencer.
  always_comb begin
    sym_t s;
    logic neg, pos, done, proceed;
    pend_d   = pend_q | start_q;
    send_d   = send_q;
    pause_d  = pause_q;
    pc_d     = pc_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    last_d   = last_q;
    endf_d   = endf_q;
    stepsg_d = stepsg_q;
    bot_d    = bot_q;
    top_d    = top_q;
    stepsz_d = stepsz_q;
    msg_d    = msg_q;
    wrote    = 1'b0;
    written  = 16'd0;
    proceed  = 1'b1;
    neg      = 1'b0;
    pos      = 1'b0;
    done     = 1'b0;

    if (!send_q && pend_d) begin
      send_d   = 1'b1;
      pend_d   = 1'b0;
      msg_d    = message_q;
      bot_d    = band.bottom;
      top_d    = band.top;
      stepsz_d = band.step;
      pause_d  = 1'b0;
      s        = begin_sym(message_q, 4'd0, band.bottom, band.top, band.step);
      pc_d     = '0;
      cur_d    = s.cur;
      endf_d   = s.endf;
      stepsg_d = s.step;
      idx_d    = s.idx;
    end else begin
      s = '0;
    end

    if (cur_d != last_d) begin
      wrote   = 1'b1;
      written = cur_d;
      last_d  = cur_d;
    end

    if (send_d) begin
      if (pause_d) begin
        pc_d = pc_d + PcW'(1);
        if (pc_d > PcW'(PAUSE_TICKS)) begin
          pause_d  = 1'b0;
          s        = begin_sym(msg_d, idx_d, bot_d, top_d, stepsz_d);
          pc_d     = '0;
          cur_d    = s.cur;
          endf_d   = s.endf;
          stepsg_d = s.step;
          idx_d    = s.idx;
        end else begin
          proceed = 1'b0;
        end
      end
      if (proceed) begin
        neg  = stepsg_d[15];
        pos  = !neg && (stepsg_d != 16'd0);
        done = (neg && (cur_d < endf_d)) || (pos && (cur_d > endf_d));
        if (done) begin
          cur_d = 16'd0;
          if (idx_d >= 4'(SYMBOLS_PER_MESSAGE)) begin
            send_d = 1'b0;
          end else begin
            pause_d = 1'b1;
          end
        end else begin
          cur_d = cur_d + stepsg_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      send_q    <= 1'b0;
      pause_q   <= 1'b0;
      pc_q      <= '0;
      idx_q     <= 4'd0;
      cur_q     <= 16'd0;
      last_q    <= 16'd0;
      endf_q    <= 16'd0;
      stepsg_q  <= 16'd0;
      bot_q     <= 16'd0;
      top_q     <= 16'd0;
      stepsz_q  <= 16'd0;
      msg_q     <= 8'd0;
    end else begin
      if (s_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (advance) begin
        pend_q   <= pend_d;
        send_q   <= send_d;
        pause_q  <= pause_d;
        pc_q     <= pc_d;
        idx_q    <= idx_d;
        cur_q    <= cur_d;
        last_q   <= last_d;
        endf_q   <= endf_d;
        stepsg_q <= stepsg_d;
        bot_q    <= bot_d;
        top_q    <= top_d;
        stepsz_q <= stepsz_d;
        msg_q    <= msg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      start_q <= s_axis_tdata[0];
    end
    if (advance) begin
      out_write_q <= wrote;
      out_value_q <= written;
      out_busy_q  <= send_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_busy_q, out_value_q, out_write_q};

`ifndef NO_ASSERTIONS
  a_settle_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q != '0) |-> !s_axis_tready)
    else $error("input taken while the scaling pipeline settles");

  a_busy_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_busy_q == send_q))
    else $error("busy flag differs from the sequencer state");

  a_silent_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_write_q) |-> (out_value_q == 16'd0))
    else $error("value reported without a frequency write");

  a_pause_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PcW'(PAUSE_TICKS + 1))
    else $error("pause counter out of range");

  a_idle_no_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!send_q && $past(advance)) |-> (cur_q == 16'd0 || !pause_q))
    else $error("pause without a message in progress");
`endif

endmodule
